// ===== sv/fba_pkg.sv =====
`default_nettype none
package fba_pkg;

  // Default geometry of the frame pool
  localparam int NUM_FRAMES_DEF  = 1024;
  localparam int FRAME_SHIFT_DEF = 12;

  // Bitmap word geometry
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int BND_W     = 11;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Register indexes
  localparam logic REG_BOUNDARY = 1'b0;

  typedef struct packed {
    logic        command;
    logic [31:0] frame_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_addr;
    logic        failed;
  } rsp_t;

  // Result of searching one bitmap word for a free frame
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_pos;
  } find_t;

endpackage
`default_nettype wire

// ===== sv/fba_ram.sv =====
`default_nettype none
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/fba_word_find.sv =====
`default_nettype none
module fba_word_find
  import fba_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [BIT_W-1:0]     lo,
  input  wire logic [BIT_W:0]       hi,
  output find_t                     res
);

  logic [WORD_BITS-1:0] free_bits;

  // Mark frames that are clear and inside the search window
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_bits[b] = !word[b] && (BIT_W'(b) >= lo) && ((BIT_W+1)'(b) < hi);
    end
  end

  // Pick the lowest free frame
  always_comb begin
    res.found   = |free_bits;
    res.bit_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        res.bit_pos = BIT_W'(b);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/frame_bitmap_allocator.sv =====
// Free: an address outside the pool is answered from the transfer, else via the S_FREE write.
// Allocate: boundary past the end is answered from the transfer; else the scan runs from the
//   boundary's word to a free frame or the last word, one 32-bit word read per cycle.
// One command at a time; busy drops in the result cycle, which may take the next transfer.
//   Results cannot be stalled.
// Reset: synchronous; a clearing pass of ceil(NUM_FRAMES/32) words, busy high.
`default_nettype none
module frame_bitmap_allocator
  import fba_pkg::*;
#(
  parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
  parameter int FRAME_SHIFT = FRAME_SHIFT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  output logic             done,
  output rsp_t             rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int WORDS     = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LAST_BITS = NUM_FRAMES - WORD_BITS * (WORDS - 1);
  localparam logic [WA-1:0]  LAST_WORD = WA'(WORDS - 1);
  localparam logic [BIT_W:0] FULL_HI   = (BIT_W+1)'(WORD_BITS);
  localparam logic [BIT_W:0] LAST_HI   = (BIT_W+1)'(LAST_BITS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FREE  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [BND_W-1:0] boundary;
  logic [WA-1:0]    chk;
  logic [WA-1:0]    start_word;
  logic [WA-1:0]    fword;
  logic [BIT_W-1:0] fbit;
  logic [WA-1:0]    clr;

  logic                 ram_we;
  logic [WA-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WA-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic        accept;
  logic [31:0] bnd_wide;
  logic        bnd_past_end;
  logic [31:0] free_idx;
  logic        free_in_range;
  logic [BIT_W-1:0] find_lo;
  logic [BIT_W:0]   find_hi;
  find_t            find;
  logic [31:0]      grant_idx;

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Register file: one boundary register
  always_ff @(posedge clk) begin
    if (rst) begin
      boundary <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BOUNDARY) begin
      boundary <= pwdata[BND_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BOUNDARY) begin
      prdata = 32'(boundary);
    end
  end

  // Decode the request
  assign bnd_wide      = 32'(boundary);
  assign bnd_past_end  = bnd_wide >= 32'(NUM_FRAMES);
  assign free_idx      = req.frame_addr >> FRAME_SHIFT;
  assign free_in_range = free_idx < 32'(NUM_FRAMES);

  // Search window inside the word under test
  assign find_lo = (chk == start_word) ? boundary[BIT_W-1:0] : '0;
  assign find_hi = (chk == LAST_WORD) ? LAST_HI : FULL_HI;

  fba_word_find u_find (
    .word (ram_rdata),
    .lo   (find_lo),
    .hi   (find_hi),
    .res  (find)
  );

  assign grant_idx = 32'({chk, find.bit_pos});

  // Sequencer: read address, write-back and next state
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = chk;
    ram_wdata  = ram_rdata;
    ram_raddr  = chk + WA'(1);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
        if (clr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && req.command == CMD_ALLOC && !bnd_past_end) begin
          ram_raddr  = bnd_wide[WA+BIT_W-1:BIT_W];
          state_next = S_SCAN;
        end else if (accept && req.command == CMD_FREE && free_in_range) begin
          ram_raddr  = free_idx[WA+BIT_W-1:BIT_W];
          state_next = S_FREE;
        end
      end
      S_SCAN: begin
        if (find.found) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata | (WORD_BITS'(1) << find.bit_pos);
          state_next = S_IDLE;
        end else if (chk == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_FREE: begin
        ram_we     = 1'b1;
        ram_waddr  = fword;
        ram_wdata  = ram_rdata & ~(WORD_BITS'(1) << fbit);
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLEAR) begin
        clr <= clr + WA'(1);
      end
      if (state == S_IDLE && accept) begin
        // Out-of-pool free and boundary past the end answer at once
        done <= (req.command == CMD_ALLOC) ? bnd_past_end : !free_in_range;
      end
      if (state == S_SCAN && (find.found || chk == LAST_WORD)) begin
        done <= 1'b1;
      end
      if (state == S_FREE) begin
        done <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rsp.granted_addr <= '0;
        rsp.failed       <= (req.command == CMD_ALLOC);
        chk              <= bnd_wide[WA+BIT_W-1:BIT_W];
        start_word       <= bnd_wide[WA+BIT_W-1:BIT_W];
        fword            <= free_idx[WA+BIT_W-1:BIT_W];
        fbit             <= free_idx[BIT_W-1:0];
      end
      S_SCAN: begin
        chk              <= chk + WA'(1);
        rsp.granted_addr <= find.found ? (grant_idx << FRAME_SHIFT) : '0;
        rsp.failed       <= !find.found;
      end
      S_FREE: begin
        rsp.granted_addr <= '0;
        rsp.failed       <= 1'b0;
      end
      default: begin
        rsp.granted_addr <= '0;
        rsp.failed       <= 1'b0;
      end
    endcase
  end

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A failed allocate never carries an address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.failed |-> rsp.granted_addr == '0)
    else $error("failed result with nonzero address");

  // Bitmap is written only by the clearing pass or a finishing command
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("bitmap write while idle");

  // An in-pool free writes back on the following cycle
  a_free_wb: assert property (@(posedge clk) disable iff (rst)
    accept && req.command == CMD_FREE && free_in_range |=> ram_we && state == S_FREE)
    else $error("free did not write back");

  // The scan never runs past the last bitmap word
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> chk <= LAST_WORD)
    else $error("scan word out of range");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top
  import fba_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FRAMES = NUM_FRAMES_DEF;
  localparam int FRAME_SHIFT = FRAME_SHIFT_DEF;
  localparam logic [31:0] OFFSET_MASK = 32'((64'd1 << FRAME_SHIFT) - 1);
  localparam logic [2:0] BOUNDARY_ADDR = {REG_BOUNDARY, 2'b00};
  // longest allocate scan plus margin
  localparam int SETTLE_CYCLES = NUM_FRAMES / 32 + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Frame pool image and boundary tracked alongside the block
  logic model_taken [NUM_FRAMES] = '{default: 1'b0};
  logic [BND_W-1:0] model_boundary = '0;

  req_t cmd_queue [$];
  rsp_t expected_grants [$];
  int idle_left = 0;
  bit no_idle = 1'b0;
  int err_count = 0;

  frame_bitmap_allocator #(
    .NUM_FRAMES (NUM_FRAMES),
    .FRAME_SHIFT(FRAME_SHIFT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .rsp    (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Apply one command to the pool image and return the grant it yields
  function automatic rsp_t predict_frame_cmd(req_t r);
    rsp_t res;
    logic [31:0] idx;
    res = '0;
    if (r.command == CMD_ALLOC) begin
      res.failed = 1'b1;
      for (int i = int'(model_boundary); i < NUM_FRAMES; i++) begin
        if (!model_taken[i]) begin
          model_taken[i] = 1'b1;
          res.granted_addr = 32'(longint'(i) << FRAME_SHIFT);
          res.failed = 1'b0;
          break;
        end
      end
    end else begin
      idx = r.frame_addr >> FRAME_SHIFT;
      if (idx < NUM_FRAMES) model_taken[idx] = 1'b0;
    end
    return res;
  endfunction

  // Driver: hold the command until the transfer, then idle or load the next
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_grants.push_back(predict_frame_cmd(req));
        idle_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (idle_left == 0 && cmd_queue.size() != 0) begin
        req <= cmd_queue.pop_front();
        start <= 1'b1;
      end else begin
        if (idle_left != 0) idle_left--;
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expected grant
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_grants.size() == 0) begin
        flag_error("result with none pending", rsp.granted_addr, 32'h0);
      end else begin
        want = expected_grants.pop_front();
        if (rsp.granted_addr !== want.granted_addr)
          flag_error("granted_addr", rsp.granted_addr, want.granted_addr);
        if (rsp.failed !== want.failed)
          flag_error("failed", 32'(rsp.failed), 32'(want.failed));
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_boundary(input int value);
    logic [31:0] rd;
    apb_access(1'b1, BOUNDARY_ADDR, 32'(value), rd);
    model_boundary = BND_W'(value);
    apb_access(1'b0, BOUNDARY_ADDR, 32'h0, rd);
    if (rd !== 32'(model_boundary))
      flag_error("boundary readback", rd, 32'(model_boundary));
  endtask

  task automatic queue_cmd(input logic cmd, input logic [31:0] addr);
    req_t r;
    r.command = cmd;
    r.frame_addr = addr;
    cmd_queue.push_back(r);
  endtask

  // Mostly allocates; most frees land near the boundary so the pool fills and drains around it
  task automatic queue_random_cmds(input int count, input int bnd);
    int lo;
    int pick;
    logic [31:0] addr;
    lo = (bnd > NUM_FRAMES - 64) ? NUM_FRAMES - 64 : bnd;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      addr = $urandom();
      if (pick < 55) begin
        queue_cmd(CMD_ALLOC, addr);
      end else if (pick < 85) begin
        queue_cmd(CMD_FREE, 32'(longint'(lo + $urandom_range(0, 63)) << FRAME_SHIFT)
                  | (addr & OFFSET_MASK));
      end else if (pick < 93) begin
        queue_cmd(CMD_FREE, 32'(longint'($urandom_range(0, NUM_FRAMES - 1)) << FRAME_SHIFT)
                  | (addr & OFFSET_MASK));
      end else begin
        queue_cmd(CMD_FREE, addr);
      end
    end
  endtask

  // Hold off until every command is through and its result has come back
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || start || expected_grants.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int bounds [6];
    bounds = '{0, 990, 0, 1024, 1020, 512};
    bounds[2] = $urandom_range(0, NUM_FRAMES);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Boundary at zero: grants, offsets, outside and repeated frees
    set_boundary(0);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
    queue_cmd(CMD_ALLOC, 32'h1234_5678);
    queue_cmd(CMD_FREE, 32'h0000_1FFF);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    queue_cmd(CMD_FREE, 32'h0000_5000);
    queue_cmd(CMD_FREE, 32'hFFFF_FFFF);
    queue_cmd(CMD_FREE, 32'(longint'(NUM_FRAMES) << FRAME_SHIFT));
    queue_cmd(CMD_FREE, 32'(longint'(NUM_FRAMES) << FRAME_SHIFT) - 1);
    queue_cmd(CMD_FREE, 32'h0000_0000);
    queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
    wait_drained();

    // Boundary past the end: every allocate fails, frees below still clear
    set_boundary(NUM_FRAMES);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
    queue_cmd(CMD_FREE, 32'h0000_0ABC);
    wait_drained();

    // Single frame left: take it, run out, give it back
    set_boundary(NUM_FRAMES - 1);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    queue_cmd(CMD_FREE, 32'(longint'(NUM_FRAMES - 1) << FRAME_SHIFT) | 32'h123);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    queue_cmd(CMD_FREE, 32'h0000_2000);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    wait_drained();

    set_boundary(1);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    queue_cmd(CMD_ALLOC, 32'h0000_0000);
    wait_drained();

    // Random phases across several boundaries
    for (int ph = 0; ph < 6; ph++) begin
      set_boundary(bounds[ph]);
      no_idle = (ph == 1 || ph == 4);
      if (ph == 2) begin
        queue_random_cmds(50, bounds[ph]);
        wait_drained();
        queue_random_cmds(50, bounds[ph]);
      end else begin
        queue_random_cmds(100, bounds[ph]);
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
